// File: src/assert_macros.svh
// assertion helpers shared by the rtl
// each macro checks on the rising edge and is switched off during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_SAME(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// File: src/dosf_pkg.sv
`timescale 1ns / 1ps

package dosf_pkg;

  // parse phase
  localparam logic [1:0] PH_CODE   = 2'd0;
  localparam logic [1:0] PH_LEN    = 2'd1;
  localparam logic [1:0] PH_DATA   = 2'd2;
  localparam logic [1:0] PH_IGNORE = 2'd3;

  // byte classification
  localparam logic [2:0] KIND_PAD  = 3'd0;
  localparam logic [2:0] KIND_CODE = 3'd1;
  localparam logic [2:0] KIND_LEN  = 3'd2;
  localparam logic [2:0] KIND_DATA = 3'd3;
  localparam logic [2:0] KIND_END  = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_TRUNC = 2'd1;
  localparam logic [1:0] ST_OVER  = 2'd2;

  localparam logic [7:0]  PAD_CODE          = 8'd0;
  localparam logic [7:0]  END_CODE          = 8'd255;
  localparam logic [11:0] MERGE_LIMIT_RESET = 12'd1500;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       is_last;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  byte_kind;
    logic [7:0]  option_code;
    logic [7:0]  data_byte;
    logic        data_valid;
    logic        option_done;
    logic [11:0] merged_length;
    logic [1:0]  status;
  } out_word_t;

  // handshake between the holding stage and the result register
  typedef struct packed {
    logic load;
    logic busy;
  } stage_ctl_t;

endpackage

// File: src/dosf_framer.sv
`timescale 1ns / 1ps

module dosf_framer (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  dosf_pkg::in_word_t item,
  input  logic [11:0]        merge_limit,
  output dosf_pkg::out_word_t result
);
  import dosf_pkg::*;

  logic [1:0]  phase, phase_next;
  logic [7:0]  current_code, current_code_next;
  logic [7:0]  bytes_left, bytes_left_next;
  logic [11:0] group_length, group_length_next;
  logic        group_open, group_open_next;
  logic        group_mergeable, group_mergeable_next;

  logic [12:0] sum;
  logic [7:0]  left_dec;
  logic [7:0]  b;
  logic        last;

  assign b        = item.in_byte;
  assign last     = item.is_last;
  assign sum      = {1'b0, group_length} + {5'b0, b};
  assign left_dec = (bytes_left != 8'd0) ? bytes_left - 8'd1 : 8'd0;

  always_comb begin
    result               = '0;
    result.byte_kind     = KIND_END;
    phase_next           = phase;
    current_code_next    = current_code;
    bytes_left_next      = bytes_left;
    group_length_next    = group_length;
    group_open_next      = group_open;
    group_mergeable_next = group_mergeable;

    unique case (phase)
      PH_CODE: begin
        if (b == PAD_CODE || b == END_CODE) begin
          result.byte_kind = (b == PAD_CODE) ? KIND_PAD : KIND_END;
          if (group_open) begin
            result.option_done   = 1'b1;
            result.merged_length = group_length;
          end
          group_open_next = 1'b0;
          if (b == END_CODE) begin
            phase_next = PH_IGNORE;
          end
        end else begin
          result.byte_kind   = KIND_CODE;
          result.option_code = b;
          // a fresh code closes the previous run unless it continues it
          if (!(group_open && b == current_code && group_mergeable)) begin
            if (group_open) begin
              result.option_done   = 1'b1;
              result.merged_length = group_length;
            end
            current_code_next    = b;
            group_length_next    = '0;
            group_mergeable_next = 1'b0;
            group_open_next      = 1'b1;
          end
          phase_next = PH_LEN;
          if (last) begin
            result.status = ST_TRUNC;
          end
        end
      end
      PH_LEN: begin
        result.byte_kind   = KIND_LEN;
        result.option_code = current_code;
        if (group_mergeable && sum > {1'b0, merge_limit}) begin
          result.status   = ST_OVER;
          group_open_next = 1'b0;
          phase_next      = PH_IGNORE;
        end else begin
          if (!group_mergeable) begin
            group_mergeable_next = (b != 8'd0);
          end
          group_length_next = sum[11:0];
          bytes_left_next   = b;
          phase_next        = (b != 8'd0) ? PH_DATA : PH_CODE;
          if (last) begin
            if (b != 8'd0) begin
              result.status = ST_TRUNC;
            end else begin
              result.option_done   = 1'b1;
              result.merged_length = sum[11:0];
            end
          end
        end
      end
      PH_DATA: begin
        result.byte_kind   = KIND_DATA;
        result.option_code = current_code;
        result.data_byte   = b;
        result.data_valid  = 1'b1;
        bytes_left_next    = left_dec;
        if (left_dec == 8'd0) begin
          phase_next = PH_CODE;
        end
        if (last) begin
          if (left_dec != 8'd0) begin
            result.status = ST_TRUNC;
          end else begin
            result.option_done   = 1'b1;
            result.merged_length = group_length;
          end
        end
      end
      default: begin
        result.byte_kind = KIND_END;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || (step && last)) begin
      phase           <= PH_CODE;
      current_code    <= '0;
      bytes_left      <= '0;
      group_length    <= '0;
      group_open      <= 1'b0;
      group_mergeable <= 1'b0;
    end else if (step) begin
      phase           <= phase_next;
      current_code    <= current_code_next;
      bytes_left      <= bytes_left_next;
      group_length    <= group_length_next;
      group_open      <= group_open_next;
      group_mergeable <= group_mergeable_next;
    end
  end

endmodule

// File: src/dosf_out_reg.sv
`timescale 1ns / 1ps

module dosf_out_reg (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 pending,
  input  dosf_pkg::out_word_t  result,
  output dosf_pkg::stage_ctl_t ctl,
  output logic                 frame_valid,
  input  logic                 frame_stall,
  output dosf_pkg::out_word_t  frame
);
  import dosf_pkg::*;

  // the register takes a new word when empty or when its word leaves now
  assign ctl.load = pending && (!frame_valid || !frame_stall);
  assign ctl.busy = frame_valid && frame_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= 1'b0;
    end else if (ctl.load) begin
      frame_valid <= 1'b1;
    end else if (!frame_stall) begin
      frame_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      frame <= result;
    end
  end

endmodule

// File: src/dhcp_option_stream_framer.sv
`timescale 1ns / 1ps
// channel   valid         stall         word
// ------    -----------   -----------   -------------------------------
// input     opt_valid     opt_stall     opt   (in_byte, is_last)
// output    frame_valid   frame_stall   frame (kind, code, data, done, ..)
// config    merge_limit_we              merge_limit_wdata (12 bit)
//
// one byte per cycle sustained while the output does not stall; an accepted word
// goes into the holding register, then through the framer step into the
// result register
// rst is synchronous: merge_limit returns to 1500 and the parse restarts
// an output stall backs up through the holding register; one word may wait
// there while the result register holds its word

module dhcp_option_stream_framer (
  input  logic                clk,
  input  logic                rst,
  // configuration
  input  logic                merge_limit_we,
  input  logic [11:0]         merge_limit_wdata,
  // byte stream in
  input  logic                opt_valid,
  output logic                opt_stall,
  input  dosf_pkg::in_word_t  opt,
  // classified stream out
  output logic                frame_valid,
  input  logic                frame_stall,
  output dosf_pkg::out_word_t frame
);
  import dosf_pkg::*;

  `include "assert_macros.svh"

  logic        [11:0] merge_limit;
  logic               hold_valid;
  in_word_t           hold_word;
  out_word_t          result;
  stage_ctl_t         ctl;
  logic               opt_take;

  // merge limit register; the user must write it only while the framer is idle, the block does not enforce this
  always_ff @(posedge clk) begin
    if (rst) begin
      merge_limit <= MERGE_LIMIT_RESET;
    end else if (merge_limit_we) begin
      merge_limit <= merge_limit_wdata;
    end
  end

  // holding register in front of the framer step
  // a held word blocks a new one only when it cannot move on
  assign opt_stall = hold_valid && !ctl.load;
  assign opt_take  = opt_valid && !opt_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (opt_take) begin
      hold_valid <= 1'b1;
    end else if (ctl.load) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (opt_take) begin
      hold_word <= opt;
    end
  end

  // parse state advances exactly when the held word enters the result register
  dosf_framer u_framer (
    .clk         (clk),
    .rst         (rst),
    .step        (ctl.load),
    .item        (hold_word),
    .merge_limit (merge_limit),
    .result      (result)
  );

  dosf_out_reg u_out_reg (
    .clk         (clk),
    .rst         (rst),
    .pending     (hold_valid),
    .result      (result),
    .ctl         (ctl),
    .frame_valid (frame_valid),
    .frame_stall (frame_stall),
    .frame       (frame)
  );

  // a held word never moves on while the result register is blocked
  `ASSERT_SAME(a_no_load_when_busy, clk, rst, ctl.busy, !ctl.load)
  // a held word that could not move stays held
  `ASSERT_NEXT(a_hold_kept, clk, rst, hold_valid && !ctl.load, hold_valid)
  // value bytes appear only on data kind
  `ASSERT_SAME(a_data_kind, clk, rst, frame_valid, frame.data_valid == (frame.byte_kind == KIND_DATA))
  // the over-limit flag only rides on a length byte
  `ASSERT_SAME(a_over_on_len, clk, rst, frame_valid && frame.status == ST_OVER, frame.byte_kind == KIND_LEN)

endmodule

// File: tb/tb_dhcp_option_stream_framer.sv
`timescale 1ns / 1ps

module tb_dhcp_option_stream_framer;
  import dosf_pkg::*;

  // one row of the directed table: either a byte to send or a limit write
  typedef struct {
    logic [7:0]  b;
    logic        last;
    bit          pinned;
    out_word_t   want;
    bit          is_cfg;
    logic [11:0] cfg_val;
  } step_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        merge_limit_we = 1'b0;
  logic [11:0] merge_limit_wdata = '0;
  logic        opt_valid = 1'b0;
  logic        opt_stall;
  in_word_t    opt = '0;
  logic        frame_valid;
  logic        frame_stall = 1'b0;
  out_word_t   frame;

  // a hand-written expectation travels alongside the byte it belongs to
  logic        pin_valid = 1'b0;
  out_word_t   pin_word = '0;

  // receiver behaviour; sink_idle and hold_req are written with nonblocking assignments by the main process
  int unsigned sink_idle = 0;
  logic        hold_req = 1'b0;
  bit          hold_seen;
  int          hold_left;

  // framer state as the predictor sees it
  logic [1:0]  ph;
  logic [7:0]  cur_code;
  logic [7:0]  left;
  logic [11:0] grp_len;
  logic        grp_open;
  logic        grp_merge;
  logic [11:0] limit;

  out_word_t   expected_frames[$];
  step_row_t   steps[$];
  int          mismatches;
  int          words_seen;

  dhcp_option_stream_framer dut (
    .clk               (clk),
    .rst               (rst),
    .merge_limit_we    (merge_limit_we),
    .merge_limit_wdata (merge_limit_wdata),
    .opt_valid         (opt_valid),
    .opt_stall         (opt_stall),
    .opt               (opt),
    .frame_valid       (frame_valid),
    .frame_stall       (frame_stall),
    .frame             (frame)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // generous ceiling on the whole run
  initial begin
    #400000;
    $display("dhcp_option_stream_framer test failed");
    $finish;
  end

  task automatic report(input string what, input int got, input int want);
    mismatches++;
    $display("word %0d: %s got %0d expected %0d", words_seen, what, got, want);
  endtask

  // back to the start of a packet; the limit register is kept
  function automatic void clear_packet();
    ph = PH_CODE;
    cur_code = '0;
    left = '0;
    grp_len = '0;
    grp_open = 1'b0;
    grp_merge = 1'b0;
  endfunction

  // classifies one byte and advances the parse state
  function automatic out_word_t frame_byte(input in_word_t w);
    out_word_t  r;
    logic [7:0] b;
    r = '0;
    r.byte_kind = KIND_END;
    b = w.in_byte;
    case (ph)
      PH_CODE: begin
        if (b == PAD_CODE || b == END_CODE) begin
          r.byte_kind = (b == PAD_CODE) ? KIND_PAD : KIND_END;
          if (grp_open) begin
            r.option_done = 1'b1;
            r.merged_length = grp_len;
          end
          grp_open = 1'b0;
          if (b == END_CODE) ph = PH_IGNORE;
        end else begin
          r.byte_kind = KIND_CODE;
          r.option_code = b;
          // same code after a non-empty first instance continues the run
          if (!(grp_open && b == cur_code && grp_merge)) begin
            if (grp_open) begin
              r.option_done = 1'b1;
              r.merged_length = grp_len;
            end
            cur_code = b;
            grp_len = '0;
            grp_merge = 1'b0;
            grp_open = 1'b1;
          end
          ph = PH_LEN;
          if (w.is_last) r.status = ST_TRUNC;
        end
      end
      PH_LEN: begin
        r.byte_kind = KIND_LEN;
        r.option_code = cur_code;
        if (grp_merge && (13'(grp_len) + 13'(b)) > 13'(limit)) begin
          // over the limit: drop the option and ignore the rest of the packet
          r.status = ST_OVER;
          grp_open = 1'b0;
          ph = PH_IGNORE;
        end else begin
          if (!grp_merge) grp_merge = (b != 0);
          grp_len = grp_len + 12'(b);
          left = b;
          ph = (b != 0) ? PH_DATA : PH_CODE;
          if (w.is_last) begin
            if (b != 0) begin
              r.status = ST_TRUNC;
            end else begin
              r.option_done = 1'b1;
              r.merged_length = grp_len;
            end
          end
        end
      end
      PH_DATA: begin
        r.byte_kind = KIND_DATA;
        r.option_code = cur_code;
        r.data_byte = b;
        r.data_valid = 1'b1;
        if (left > 0) left = left - 8'd1;
        if (left == 0) ph = PH_CODE;
        if (w.is_last) begin
          if (left > 0) begin
            r.status = ST_TRUNC;
          end else begin
            r.option_done = 1'b1;
            r.merged_length = grp_len;
          end
        end
      end
      default: ;
    endcase
    if (w.is_last) clear_packet();
    return r;
  endfunction

  // both handshakes are sampled here at the edge, before any update lands
  always @(posedge clk) begin
    out_word_t want;
    if (rst) begin
      limit = MERGE_LIMIT_RESET;
      clear_packet();
      expected_frames.delete();
    end else begin
      if (frame_valid && !frame_stall) begin
        if (expected_frames.size() == 0) begin
          report("unexpected word, kind", frame.byte_kind, -1);
        end else begin
          want = expected_frames.pop_front();
          if (frame.byte_kind !== want.byte_kind)
            report("byte_kind", frame.byte_kind, want.byte_kind);
          if (frame.option_code !== want.option_code)
            report("option_code", frame.option_code, want.option_code);
          if (frame.data_byte !== want.data_byte)
            report("data_byte", frame.data_byte, want.data_byte);
          if (frame.data_valid !== want.data_valid)
            report("data_valid", frame.data_valid, want.data_valid);
          if (frame.option_done !== want.option_done)
            report("option_done", frame.option_done, want.option_done);
          if (frame.merged_length !== want.merged_length)
            report("merged_length", frame.merged_length, want.merged_length);
          if (frame.status !== want.status)
            report("status", frame.status, want.status);
        end
        words_seen++;
      end
      if (opt_valid && !opt_stall) begin
        // the predictor always runs so that its state stays in step
        want = frame_byte(opt);
        if (pin_valid) want = pin_word;
        expected_frames.push_back(want);
      end
      if (merge_limit_we) limit = merge_limit_wdata;
    end
  end

  // receiver: random stalls, plus one long hold-off when asked for
  always @(posedge clk) begin
    if (hold_req && !hold_seen) begin
      hold_seen = 1'b1;
      hold_left = 150;
    end
    if (hold_left > 0) begin
      frame_stall <= 1'b1;
      hold_left--;
    end else begin
      frame_stall <= ($urandom_range(99) < sink_idle);
    end
  end

  // offers one word and holds it until the framer takes it
  task automatic send_byte(input logic [7:0] b, input logic last, input int unsigned src_idle,
                           input bit pinned, input out_word_t want);
    while ($urandom_range(99) < src_idle) begin
      opt_valid <= 1'b0;
      @(posedge clk);
    end
    opt_valid <= 1'b1;
    opt <= '{in_byte: b, is_last: last};
    pin_valid <= pinned;
    pin_word <= want;
    @(posedge clk);
    while (opt_stall) @(posedge clk);
  endtask

  // sender pauses until every expected word has come back
  task automatic wait_drain();
    opt_valid <= 1'b0;
    pin_valid <= 1'b0;
    @(posedge clk);
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input logic [11:0] v);
    merge_limit_we <= 1'b1;
    merge_limit_wdata <= v;
    @(posedge clk);
    merge_limit_we <= 1'b0;
  endtask

  // mostly short values, now and then empty or long ones
  function automatic int pick_len();
    int p;
    p = $urandom_range(99);
    if (p < 10) return 0;
    if (p < 85) return $urandom_range(1, 6);
    if (p < 97) return $urandom_range(7, 40);
    return $urandom_range(100, 255);
  endfunction

  // builds one packet (well formed, cut short, or plain noise) and sends it
  task automatic send_packet(input int unsigned src_idle, output int useful);
    logic [7:0] pkt[$];
    logic [7:0] code;
    logic [7:0] prev;
    int         nopt;
    int         reps;
    int         len;
    int         body;
    int         cut;
    pkt = {};
    prev = 8'd1;
    if ($urandom_range(99) < 8) begin
      repeat ($urandom_range(1, 8)) pkt.push_back(8'($urandom));
      body = pkt.size();
    end else begin
      nopt = $urandom_range(1, 5);
      for (int i = 0; i < nopt; i++) begin
        if ($urandom_range(99) < 15) pkt.push_back(PAD_CODE);
        code = ($urandom_range(99) < 40) ? prev : 8'($urandom_range(1, 254));
        // a run of instances with one code, to exercise merging
        reps = ($urandom_range(99) < 30) ? $urandom_range(2, 4) : 1;
        repeat (reps) begin
          len = pick_len();
          pkt.push_back(code);
          pkt.push_back(8'(len));
          repeat (len) pkt.push_back(8'($urandom));
        end
        prev = code;
      end
      if ($urandom_range(99) < 35) pkt.push_back(END_CODE);
      body = pkt.size();
      // bytes after the end marker are ignored by the framer
      if (body > 0 && pkt[body-1] == END_CODE)
        repeat ($urandom_range(0, 3)) pkt.push_back(8'($urandom));
      if ($urandom_range(99) < 15) begin
        cut = $urandom_range(1, pkt.size());
        pkt = pkt[0:cut-1];
        if (cut < body) body = cut;
      end
    end
    for (int i = 0; i < pkt.size(); i++)
      send_byte(pkt[i], (i == pkt.size() - 1), src_idle, 1'b0, '0);
    useful = body;
  endtask

  task automatic add_row(input logic [7:0] b, input logic last, input bit pinned = 1'b0,
                         input out_word_t want = '0);
    steps.push_back('{b: b, last: last, pinned: pinned, want: want,
                      is_cfg: 1'b0, cfg_val: '0});
  endtask

  initial begin
    logic [11:0] seg_limit[6];
    int          seg_items;
    int          n;
    int unsigned src_idle;

    // directed table, run first at the reset limit
    add_row(8'h00, 1'b0, 1'b1, out_word_t'{KIND_PAD, 8'h00, 8'h00, 1'b0, 1'b0, 12'd0, ST_OK});
    add_row(8'h35, 1'b0, 1'b1, out_word_t'{KIND_CODE, 8'h35, 8'h00, 1'b0, 1'b0, 12'd0, ST_OK});
    add_row(8'h01, 1'b0, 1'b1, out_word_t'{KIND_LEN, 8'h35, 8'h00, 1'b0, 1'b0, 12'd0, ST_OK});
    add_row(8'hff, 1'b0, 1'b1, out_word_t'{KIND_DATA, 8'h35, 8'hff, 1'b1, 1'b0, 12'd0, ST_OK});
    add_row(8'h35, 1'b0);                 // same code again, merged
    add_row(8'h01, 1'b0);
    add_row(8'h00, 1'b0);
    add_row(8'h01, 1'b0);                 // new code closes the merged option
    add_row(8'h00, 1'b0);                 // empty first instance
    add_row(8'h01, 1'b0);                 // same code after an empty one starts afresh
    add_row(8'h00, 1'b1);                 // packet ends on a complete empty option
    steps.push_back('{b: '0, last: 1'b0, pinned: 1'b0, want: '0, is_cfg: 1'b1, cfg_val: 12'd4});
    add_row(8'h0c, 1'b0);
    add_row(8'h02, 1'b0);
    add_row(8'h11, 1'b0);
    add_row(8'h22, 1'b0);
    add_row(8'h0c, 1'b0);
    // 2 + 3 is over a limit of 4
    add_row(8'h03, 1'b0, 1'b1, out_word_t'{KIND_LEN, 8'h0c, 8'h00, 1'b0, 1'b0, 12'd0, ST_OVER});
    add_row(8'hff, 1'b1, 1'b1, out_word_t'{KIND_END, 8'h00, 8'h00, 1'b0, 1'b0, 12'd0, ST_OK});
    // truncated on a code byte
    add_row(8'hfe, 1'b1, 1'b1, out_word_t'{KIND_CODE, 8'hfe, 8'h00, 1'b0, 1'b0, 12'd0, ST_TRUNC});
    // truncated inside the value
    add_row(8'h80, 1'b0);
    add_row(8'h02, 1'b0);
    add_row(8'h01, 1'b1, 1'b1, out_word_t'{KIND_DATA, 8'h80, 8'h01, 1'b1, 1'b0, 12'd0, ST_TRUNC});
    // truncated on a non-zero length
    add_row(8'h07, 1'b0);
    add_row(8'hff, 1'b1, 1'b1, out_word_t'{KIND_LEN, 8'h07, 8'h00, 1'b0, 1'b0, 12'd0, ST_TRUNC});
    // end marker closes an open option, the tail is ignored
    add_row(8'h02, 1'b0);
    add_row(8'h01, 1'b0);
    add_row(8'h7e, 1'b0);
    add_row(8'hff, 1'b0);
    add_row(8'h00, 1'b1, 1'b1, out_word_t'{KIND_END, 8'h00, 8'h00, 1'b0, 1'b0, 12'd0, ST_OK});

    seg_limit[0] = 12'd0;
    seg_limit[1] = 12'd4095;
    seg_limit[2] = 12'd17;
    seg_limit[3] = MERGE_LIMIT_RESET;
    seg_limit[4] = 12'd300;
    seg_limit[5] = 12'($urandom_range(4095));

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (steps[i]) begin
      if (steps[i].is_cfg) begin
        wait_drain();
        write_limit(steps[i].cfg_val);
      end else begin
        send_byte(steps[i].b, steps[i].last, 0, steps[i].pinned, steps[i].want);
      end
    end

    // random part: two segments per idling pattern, each with its own limit
    for (int seg = 0; seg < 6; seg++) begin
      wait_drain();
      write_limit(seg_limit[seg]);
      case (seg / 2)
        0: begin
          src_idle = 6;
          sink_idle <= 76;
        end
        1: begin
          src_idle = 76;
          sink_idle <= 6;
        end
        default: begin
          src_idle = 0;
          sink_idle <= 0;
        end
      endcase
      // long receiver hold-off while the sender keeps offering words
      if (seg == 4) hold_req <= 1'b1;
      seg_items = 0;
      while (seg_items < 325) begin
        send_packet(src_idle, n);
        seg_items += n;
      end
    end

    wait_drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("dhcp_option_stream_framer test passed");
    end else begin
      $display("dhcp_option_stream_framer test failed");
    end
    $finish;
  end

endmodule
